// File: src/rbf_pkg.sv
package rbf_pkg;

    localparam int FUNC_W = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int CAP_W  = 9;
    localparam int STAT_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_OVR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_DROP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHIFT     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK      = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERWRITE = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic clear_wr;
        logic exec;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
    } t_ctrl_stat;

    // a + b modulo cap, with a < cap and b <= cap
    function automatic logic [CAP_W-1:0] ring_add(
        input logic [CAP_W-1:0] a,
        input logic [CAP_W-1:0] b,
        input logic [CAP_W-1:0] cap
    );
        logic [CAP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, cap}) begin
            s = s - {1'b0, cap};
        end
        if (s >= {1'b0, cap}) begin
            s = '0;
        end
        return s[CAP_W-1:0];
    endfunction

endpackage

// File: src/ring_buffer_fifo.sv
// Circular FIFO over a DEPTH-entry store, ring length set by the capacity
// register (0 acts as 1, above DEPTH acts as DEPTH; any write empties the ring).
// Each beat is push-overwrite, push-drop, shift or peek and yields one result
// beat with data, fill count and status. After reset the store is zeroed by a
// clearing pass over all DEPTH entries during which no item is taken. In IDLE
// an item gets its operation, state update and registered store read; in READ
// it is loaded into the output register once free; no new item is taken before.
module ring_buffer_fifo #(
    parameter int DEPTH     = 256,
    parameter int ELEM_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbf_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rbf_pkg::FUNC_W-1:0]    i_func,
    input  logic [rbf_pkg::VAL_W-1:0]     i_value,
    input  logic [rbf_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rbf_pkg::VAL_W-1:0]     o_read_data,
    output logic                          o_read_valid,
    output logic [rbf_pkg::CAP_W-1:0]     o_fill_count,
    output logic [rbf_pkg::STAT_W-1:0]    o_status
);

    rbf_pkg::t_ctrl_cmd  cmd;
    rbf_pkg::t_ctrl_stat stat;

    assign o_cfg_ready = 1'b1;

    rbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rbf_dp #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_capacity   (i_capacity),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_read_data  (o_read_data),
        .o_read_valid (o_read_valid),
        .o_fill_count (o_fill_count),
        .o_status     (o_status)
    );

endmodule

// File: src/rbf_ctrl.sv
module rbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  rbf_pkg::t_ctrl_stat i_stat,
    output rbf_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear_wr = (r_state == S_CLEAR);
        o_cmd.exec     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load_out = (r_state == S_READ) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            priority if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.exec) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// File: src/rbf_dp.sv
module rbf_dp #(
    parameter int DEPTH     = 256,
    parameter int ELEM_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbf_pkg::t_ctrl_cmd            i_cmd,
    output rbf_pkg::t_ctrl_stat           o_stat,
    input  logic                          i_cfg_we,
    input  logic [rbf_pkg::CAP_W-1:0]     i_capacity,
    input  logic [rbf_pkg::FUNC_W-1:0]    i_func,
    input  logic [rbf_pkg::VAL_W-1:0]     i_value,
    input  logic [rbf_pkg::POS_W-1:0]     i_position,
    output logic [rbf_pkg::VAL_W-1:0]     o_read_data,
    output logic                          o_read_valid,
    output logic [rbf_pkg::CAP_W-1:0]     o_fill_count,
    output logic [rbf_pkg::STAT_W-1:0]    o_status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int EXT_W = IDX_W + rbf_pkg::CAP_W;
    localparam int WIDE_W = 64;

    logic [ELEM_BITS-1:0] r_mem [DEPTH];
    logic [ELEM_BITS-1:0] r_rd_data;

    logic [rbf_pkg::CAP_W-1:0] r_capacity;
    logic [rbf_pkg::CAP_W-1:0] r_oldest;
    logic [rbf_pkg::CAP_W-1:0] r_count;
    logic [IDX_W-1:0]          r_clr_addr;

    logic                       r_pend_valid;
    logic [rbf_pkg::CAP_W-1:0]  r_pend_fill;
    logic [rbf_pkg::STAT_W-1:0] r_pend_status;

    logic [rbf_pkg::VAL_W-1:0]  r_read_data;
    logic                       r_read_valid;
    logic [rbf_pkg::CAP_W-1:0]  r_fill_count;
    logic [rbf_pkg::STAT_W-1:0] r_status;

    logic [rbf_pkg::CAP_W-1:0]  cap_eff;
    logic                       full;
    logic                       empty;
    logic                       pos_bad;
    logic [rbf_pkg::CAP_W-1:0]  oldest_inc;
    logic [rbf_pkg::CAP_W-1:0]  n_oldest;
    logic [rbf_pkg::CAP_W-1:0]  n_count;
    logic                       op_we;
    logic                       op_rd;
    logic [rbf_pkg::CAP_W-1:0]  op_waddr;
    logic [rbf_pkg::CAP_W-1:0]  op_raddr;
    logic [rbf_pkg::STAT_W-1:0] op_status;
    logic [EXT_W-1:0]           waddr_ext;
    logic [EXT_W-1:0]           raddr_ext;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [ELEM_BITS-1:0]       mem_wdata;
    logic [WIDE_W-1:0]          value_wide;
    logic [WIDE_W-1:0]          rd_wide;

    assign o_stat.clear_last = (r_clr_addr == IDX_W'(DEPTH - 1));

    always_comb begin
        cap_eff = r_capacity;
        if (cap_eff == '0) begin
            cap_eff = rbf_pkg::CAP_W'(1);
        end
        if (32'(cap_eff) > DEPTH) begin
            cap_eff = rbf_pkg::CAP_W'(DEPTH);
        end
    end

    assign full       = (r_count >= cap_eff);
    assign empty      = (r_count == '0);
    assign pos_bad    = ({1'b0, i_position} >= cap_eff);
    assign oldest_inc = rbf_pkg::ring_add(r_oldest, rbf_pkg::CAP_W'(1), cap_eff);

    always_comb begin
        n_oldest  = r_oldest;
        n_count   = r_count;
        op_we     = 1'b0;
        op_rd     = 1'b0;
        op_waddr  = r_oldest;
        op_raddr  = r_oldest;
        op_status = rbf_pkg::ST_OK;
        unique case (i_func)
            rbf_pkg::FUNC_PUSH_OVR, rbf_pkg::FUNC_PUSH_DROP: begin
                if (full) begin
                    if (i_func == rbf_pkg::FUNC_PUSH_OVR) begin
                        op_we     = 1'b1;
                        n_oldest  = oldest_inc;
                        op_status = rbf_pkg::ST_OVERWRITE;
                    end else begin
                        op_status = rbf_pkg::ST_DROPPED;
                    end
                end else begin
                    op_we    = 1'b1;
                    op_waddr = rbf_pkg::ring_add(r_oldest, r_count, cap_eff);
                    n_count  = r_count + 1'b1;
                end
            end
            rbf_pkg::FUNC_SHIFT: begin
                if (empty) begin
                    op_status = rbf_pkg::ST_EMPTY;
                end else begin
                    op_rd    = 1'b1;
                    n_oldest = oldest_inc;
                    n_count  = r_count - 1'b1;
                end
            end
            rbf_pkg::FUNC_PEEK: begin
                if (pos_bad) begin
                    op_status = rbf_pkg::ST_RANGE;
                end else begin
                    op_rd    = 1'b1;
                    op_raddr = rbf_pkg::ring_add(r_oldest, {1'b0, i_position}, cap_eff);
                end
            end
            default: begin
                op_status = rbf_pkg::ST_OK;
            end
        endcase
    end

    assign waddr_ext  = EXT_W'(op_waddr);
    assign raddr_ext  = EXT_W'(op_raddr);
    assign value_wide = WIDE_W'(i_value);
    assign rd_wide    = WIDE_W'(r_rd_data);

    always_comb begin
        mem_we    = i_cmd.clear_wr || (i_cmd.exec && op_we);
        mem_waddr = waddr_ext[IDX_W-1:0];
        mem_wdata = value_wide[ELEM_BITS-1:0];
        if (i_cmd.clear_wr) begin
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.exec && op_rd) begin
            r_rd_data <= r_mem[raddr_ext[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= rbf_pkg::CAP_RESET;
            r_oldest   <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            priority if (i_cfg_we) begin
                r_capacity <= i_capacity;
                r_oldest   <= '0;
                r_count    <= '0;
            end else if (i_cmd.exec) begin
                r_oldest <= n_oldest;
                r_count  <= n_count;
            end else begin
                r_oldest <= r_oldest;
                r_count  <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pend_valid  <= op_rd;
            r_pend_fill   <= n_count;
            r_pend_status <= op_status;
        end
        if (i_cmd.load_out) begin
            r_read_data  <= r_pend_valid ? rd_wide[rbf_pkg::VAL_W-1:0] : '0;
            r_read_valid <= r_pend_valid;
            r_fill_count <= r_pend_fill;
            r_status     <= r_pend_status;
        end
    end

    assign o_read_data  = r_read_data;
    assign o_read_valid = r_read_valid;
    assign o_fill_count = r_fill_count;
    assign o_status     = r_status;

endmodule
